@@ sv/pnq_pkg.sv @@
// Package for the pixel normalizer and int8 quantizer: widths, channel constants, register codes.
`default_nettype none
package pnq_pkg;

  localparam int unsigned MAX_IMAGE_DIM_DEF       = 4096;
  localparam int unsigned MAX_BUFFER_CHANNELS_DEF = 16;

  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned NUM_STAGES = 5;

  // Field widths
  localparam int unsigned COORD_W       = 12;
  localparam int unsigned SAMPLE_W      = 8;
  localparam int unsigned Q_W           = 8;
  localparam int unsigned ADDR_W        = 29;
  localparam int unsigned RECIP_SCALE_W = 24;
  localparam int unsigned OFFSET_W      = 8;
  localparam int unsigned CHAN_OFF_W    = 4;
  localparam int unsigned ROW_WIDTH_W   = 13;
  localparam int unsigned CHANS_W       = 5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Address datapath widths
  localparam int unsigned SUM_W    = COORD_W + 1;          // coordinate plus padding
  localparam int unsigned ROWMUL_W = SUM_W + ROW_WIDTH_W;  // row index times row width
  localparam int unsigned LIN_W    = ROWMUL_W + 1;         // pixel index in buffer
  localparam int unsigned ADDRMUL_W = LIN_W + CHANS_W;

  // Quantizer datapath widths
  localparam int unsigned FIX_W       = 16;                // Q8.8 sample and mean
  localparam int unsigned ISTD_W      = 11;                // Q0.16 inverse std, values < 2^11
  localparam int unsigned MAG1_W      = FIX_W + ISTD_W;
  localparam int unsigned MAG_W       = MAG1_W + RECIP_SCALE_W;
  localparam int unsigned ROUND_SHIFT = 40;
  localparam int unsigned RND_W       = MAG_W + 1 - ROUND_SHIFT;
  localparam int unsigned QS_W        = RND_W + 1;

  localparam logic signed [QS_W-1:0] Q_MIN = QS_W'(-128);
  localparam logic signed [QS_W-1:0] Q_MAX = QS_W'(127);

  // Per-channel constants: red, green, blue
  localparam logic [FIX_W-1:0] CHAN_MEAN [NUM_CHAN] = '{
    FIX_W'(31661), FIX_W'(29768), FIX_W'(26504)
  };
  localparam logic [ISTD_W-1:0] CHAN_INV_STD [NUM_CHAN] = '{
    ISTD_W'(1122), ISTD_W'(1147), ISTD_W'(1142)
  };

  // Reset values of the configuration registers
  localparam logic [RECIP_SCALE_W-1:0] RECIP_SCALE_RST = RECIP_SCALE_W'(65536);
  localparam logic [ROW_WIDTH_W-1:0]   ROW_WIDTH_RST   = ROW_WIDTH_W'(1);
  localparam logic [CHANS_W-1:0]       CHANS_RST       = CHANS_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECIP_SCALE = 3'd0,
    REG_ZERO_POINT  = 3'd1,
    REG_ROW_OFFSET  = 3'd2,
    REG_COL_OFFSET  = 3'd3,
    REG_CHAN_OFFSET = 3'd4,
    REG_ROW_WIDTH   = 3'd5,
    REG_CHANNELS    = 3'd6
  } cfg_reg_t;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

endpackage
`default_nettype wire

@@ sv/pixel_normalize_int8_quantize.sv @@
// Top level: five-stage pixel normalize, int8 quantize and buffer address pipeline.
// Each request is registered at the end of every stage; the result comes from the last stage register.
// Throughput: one pixel per clock; the pipeline holds five requests and only a stalled
// output with every stage full drops in_ready.
// Address and quantizer paths run in step: one multiply or one wide add per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
`default_nettype none
module pixel_normalize_int8_quantize #(
  parameter int unsigned MAX_IMAGE_DIM       = pnq_pkg::MAX_IMAGE_DIM_DEF,
  parameter int unsigned MAX_BUFFER_CHANNELS = pnq_pkg::MAX_BUFFER_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  pnq_pkg::cfg_idx_t                      cfg_index,
  input  pnq_pkg::cfg_data_t                     cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [pnq_pkg::COORD_W-1:0]            in_pixel_row,
  input  logic [pnq_pkg::COORD_W-1:0]            in_pixel_col,
  input  logic [pnq_pkg::SAMPLE_W-1:0]           in_red,
  input  logic [pnq_pkg::SAMPLE_W-1:0]           in_green,
  input  logic [pnq_pkg::SAMPLE_W-1:0]           in_blue,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pnq_pkg::ADDR_W-1:0]             out_byte_address,
  output logic signed [pnq_pkg::Q_W-1:0]         out_q_red,
  output logic signed [pnq_pkg::Q_W-1:0]         out_q_green,
  output logic signed [pnq_pkg::Q_W-1:0]         out_q_blue
);
  import pnq_pkg::*;

  localparam logic [COORD_W-1:0] DIM_TOP  = COORD_W'(MAX_IMAGE_DIM - 1);
  localparam logic [CHANS_W-1:0] CHAN_TOP = CHANS_W'(MAX_BUFFER_CHANNELS);

  // Configuration registers
  logic [RECIP_SCALE_W-1:0] recip_scale_r;
  logic signed [Q_W-1:0]    zero_point_r;
  logic [OFFSET_W-1:0]      row_offset_r;
  logic [OFFSET_W-1:0]      col_offset_r;
  logic [CHAN_OFF_W-1:0]    chan_offset_r;
  logic [ROW_WIDTH_W-1:0]   row_width_r;
  logic [CHANS_W-1:0]       channels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_scale_r <= RECIP_SCALE_RST;
      zero_point_r  <= '0;
      row_offset_r  <= '0;
      col_offset_r  <= '0;
      chan_offset_r <= '0;
      row_width_r   <= ROW_WIDTH_RST;
      channels_r    <= CHANS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RECIP_SCALE: recip_scale_r <= cfg_wdata[RECIP_SCALE_W-1:0];
        REG_ZERO_POINT:  zero_point_r  <= $signed(cfg_wdata[Q_W-1:0]);
        REG_ROW_OFFSET:  row_offset_r  <= cfg_wdata[OFFSET_W-1:0];
        REG_COL_OFFSET:  col_offset_r  <= cfg_wdata[OFFSET_W-1:0];
        REG_CHAN_OFFSET: chan_offset_r <= cfg_wdata[CHAN_OFF_W-1:0];
        REG_ROW_WIDTH:   row_width_r   <= cfg_wdata[ROW_WIDTH_W-1:0];
        REG_CHANNELS:    channels_r    <= cfg_wdata[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance chain
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (adv[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // Stage 1: clamp coordinates and channel count, add padding, form |x - mean|
  logic [SAMPLE_W-1:0] smp [NUM_CHAN];
  logic [COORD_W-1:0]  row_cl, col_cl;
  logic [FIX_W-1:0]    x_fix [NUM_CHAN];

  logic [SUM_W-1:0]   row_sum_r, row_sum_nxt, col_sum1_r, col_sum1_nxt;
  logic [CHANS_W-1:0] chans1_r, chans1_nxt;
  logic [FIX_W-1:0]   diff_r [NUM_CHAN];
  logic [FIX_W-1:0]   diff_nxt [NUM_CHAN];
  logic [NUM_CHAN-1:0] neg1_r, neg1_nxt;

  always_comb begin
    smp[0] = in_red;
    smp[1] = in_green;
    smp[2] = in_blue;
    row_cl = (32'(in_pixel_row) >= MAX_IMAGE_DIM) ? DIM_TOP : in_pixel_row;
    col_cl = (32'(in_pixel_col) >= MAX_IMAGE_DIM) ? DIM_TOP : in_pixel_col;
    row_sum_nxt  = SUM_W'(row_cl) + SUM_W'(row_offset_r);
    col_sum1_nxt = SUM_W'(col_cl) + SUM_W'(col_offset_r);
    chans1_nxt   = (32'(channels_r) > MAX_BUFFER_CHANNELS) ? CHAN_TOP : channels_r;
    for (int c = 0; c < NUM_CHAN; c++) begin
      x_fix[c]    = {smp[c], {(FIX_W - SAMPLE_W){1'b0}}};
      neg1_nxt[c] = x_fix[c] < CHAN_MEAN[c];
      diff_nxt[c] = neg1_nxt[c] ? (CHAN_MEAN[c] - x_fix[c]) : (x_fix[c] - CHAN_MEAN[c]);
    end
  end

  // Stage 2: row times buffer width, |diff| times inverse std
  logic [ROWMUL_W-1:0] rowmul_r, rowmul_nxt;
  logic [SUM_W-1:0]    col_sum2_r;
  logic [CHANS_W-1:0]  chans2_r;
  logic [MAG1_W-1:0]   mag1_r [NUM_CHAN];
  logic [MAG1_W-1:0]   mag1_nxt [NUM_CHAN];
  logic [NUM_CHAN-1:0] neg2_r;

  always_comb begin
    rowmul_nxt = ROWMUL_W'(row_sum_r) * ROWMUL_W'(row_width_r);
    for (int c = 0; c < NUM_CHAN; c++) begin
      mag1_nxt[c] = MAG1_W'(diff_r[c]) * MAG1_W'(CHAN_INV_STD[c]);
    end
  end

  // Stage 3: add column, multiply by inverse scale
  logic [LIN_W-1:0]    lin_r, lin_nxt;
  logic [CHANS_W-1:0]  chans3_r;
  logic [MAG_W-1:0]    mag_r [NUM_CHAN];
  logic [MAG_W-1:0]    mag_nxt [NUM_CHAN];
  logic [NUM_CHAN-1:0] neg3_r;

  always_comb begin
    lin_nxt = LIN_W'(rowmul_r) + LIN_W'(col_sum2_r);
    for (int c = 0; c < NUM_CHAN; c++) begin
      mag_nxt[c] = MAG_W'(mag1_r[c]) * MAG_W'(recip_scale_r);
    end
  end

  // Stage 4: pixel index times channels, round magnitude half up
  logic [ADDRMUL_W-1:0] addrmul;
  logic [ADDR_W-1:0]    addr4_r, addr4_nxt;
  logic [MAG_W:0]       rnd_sum [NUM_CHAN];
  logic [RND_W-1:0]     rnd_r [NUM_CHAN];
  logic [RND_W-1:0]     rnd_nxt [NUM_CHAN];
  logic [NUM_CHAN-1:0]  neg4_r;

  always_comb begin
    addrmul   = ADDRMUL_W'(lin_r) * ADDRMUL_W'(chans3_r);
    addr4_nxt = addrmul[ADDR_W-1:0];
    for (int c = 0; c < NUM_CHAN; c++) begin
      rnd_sum[c] = {1'b0, mag_r[c]} + ((MAG_W + 1)'(1) << (ROUND_SHIFT - 1));
      rnd_nxt[c] = rnd_sum[c][MAG_W:ROUND_SHIFT];
    end
  end

  // Stage 5: channel offset, restore sign, add zero point, saturate
  logic [ADDR_W-1:0]      addr5_nxt;
  logic signed [QS_W-1:0] q_signed [NUM_CHAN];
  logic signed [QS_W-1:0] q_sum [NUM_CHAN];
  logic signed [Q_W-1:0]  q_nxt [NUM_CHAN];
  logic [ADDR_W-1:0]      addr5_r;
  logic signed [Q_W-1:0]  q_r [NUM_CHAN];

  always_comb begin
    addr5_nxt = addr4_r + ADDR_W'(chan_offset_r);
    for (int c = 0; c < NUM_CHAN; c++) begin
      q_signed[c] = neg4_r[c] ? -$signed({1'b0, rnd_r[c]}) : $signed({1'b0, rnd_r[c]});
      q_sum[c]    = q_signed[c] + QS_W'(zero_point_r);
      if (q_sum[c] < Q_MIN) begin
        q_nxt[c] = Q_MIN[Q_W-1:0];
      end else if (q_sum[c] > Q_MAX) begin
        q_nxt[c] = Q_MAX[Q_W-1:0];
      end else begin
        q_nxt[c] = q_sum[c][Q_W-1:0];
      end
    end
  end

  // Payload registers: advance with their stage, hold when stalled
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      row_sum_r  <= row_sum_nxt;
      col_sum1_r <= col_sum1_nxt;
      chans1_r   <= chans1_nxt;
      neg1_r     <= neg1_nxt;
      diff_r     <= diff_nxt;
    end
    if (adv[1]) begin
      rowmul_r   <= rowmul_nxt;
      col_sum2_r <= col_sum1_r;
      chans2_r   <= chans1_r;
      neg2_r     <= neg1_r;
      mag1_r     <= mag1_nxt;
    end
    if (adv[2]) begin
      lin_r    <= lin_nxt;
      chans3_r <= chans2_r;
      neg3_r   <= neg2_r;
      mag_r    <= mag_nxt;
    end
    if (adv[3]) begin
      addr4_r <= addr4_nxt;
      neg4_r  <= neg3_r;
      rnd_r   <= rnd_nxt;
    end
    if (adv[4]) begin
      addr5_r <= addr5_nxt;
      q_r     <= q_nxt;
    end
  end

  assign out_byte_address = addr5_r;
  assign out_q_red        = q_r[0];
  assign out_q_green      = q_r[1];
  assign out_q_blue       = q_r[2];

  // A ready sink never backs up into the input
  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // Input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && (&vld_r)))
    else $error("input stalled with room in the pipeline");

  // A request accepted while the output keeps out_ready high reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("request lost in the pipeline");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the pixel normalize and int8 quantize pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pnq_pkg::*;

  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned MAX_CH      = 16;

  // Per-channel mean (Q8.8) and inverse std (Q0.16)
  localparam int unsigned MEAN_RED   = 31661;
  localparam int unsigned MEAN_GREEN = 29768;
  localparam int unsigned MEAN_BLUE  = 26504;
  localparam int unsigned ISTD_RED   = 1122;
  localparam int unsigned ISTD_GREEN = 1147;
  localparam int unsigned ISTD_BLUE  = 1142;

  localparam logic signed [Q_W-1:0] SAT_LO = 8'sh80;
  localparam logic signed [Q_W-1:0] SAT_HI = 8'sh7F;

  // Index with no register behind it; also fills the index slot of pixel rows
  localparam cfg_idx_t REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic signed [Q_W-1:0] q_red;
    logic signed [Q_W-1:0] q_green;
    logic signed [Q_W-1:0] q_blue;
  } quant_t;

  typedef struct packed {
    logic [RECIP_SCALE_W-1:0] recip_scale;
    logic signed [Q_W-1:0]    zero_pt;
    logic [OFFSET_W-1:0]      row_off;
    logic [OFFSET_W-1:0]      col_off;
    logic [CHAN_OFF_W-1:0]    chan_off;
    logic [ROW_WIDTH_W-1:0]   row_w;
    logic [CHANS_W-1:0]       chans;
  } quant_cfg_t;

  typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    cfg_idx_t   idx;
    cfg_data_t  data;
    pixel_t     px;
    bit         given;
    quant_t     q;
  } step_t;

  localparam int unsigned DIR_N = 28;
  localparam step_t DIR_TBL [DIR_N] = '{
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{29'd0, -8'sd2, -8'sd2, -8'sd2}},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{29'd24570, 8'sd2, 8'sd2, 8'sd3}},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'hAAA, 12'h555, 8'hAA, 8'h55, 8'h0F}, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'h555, 12'hAAA, 8'd124, 8'd116, 8'd104}, 1'b0, '0},
    // saturate both ways
    '{STEP_WRITE, REG_RECIP_SCALE, 24'hFFFFFF, '0, 1'b0, '0},
    '{STEP_WRITE, REG_ZERO_POINT, 24'h00007F, '0, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{29'd0, SAT_LO, SAT_LO, SAT_LO}},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd0, 12'd1, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{29'd3, SAT_HI, SAT_HI, SAT_HI}},
    // zero scale: every channel lands on the zero point
    '{STEP_WRITE, REG_RECIP_SCALE, 24'h000000, '0, 1'b0, '0},
    '{STEP_WRITE, REG_ZERO_POINT, 24'h000080, '0, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd1, 12'd2, 8'd255, 8'd0, 8'd128}, 1'b1,
      '{29'd9, SAT_LO, SAT_LO, SAT_LO}},
    '{STEP_WRITE, REG_ZERO_POINT, 24'hFFFF7F, '0, 1'b0, '0},
    // largest padding: address wraps, channel count clamps to 16
    '{STEP_WRITE, REG_ROW_OFFSET, 24'h0000FF, '0, 1'b0, '0},
    '{STEP_WRITE, REG_COL_OFFSET, 24'h0000FF, '0, 1'b0, '0},
    '{STEP_WRITE, REG_CHAN_OFFSET, 24'h00000F, '0, 1'b0, '0},
    '{STEP_WRITE, REG_ROW_WIDTH, 24'h001FFF, '0, 1'b0, '0},
    '{STEP_WRITE, REG_CHANNELS, 24'h00001F, '0, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd4095, 12'd4095, 8'd0, 8'd255, 8'd7}, 1'b1,
      '{29'd33292303, SAT_HI, SAT_HI, SAT_HI}},
    // degenerate shape: only the channel offset survives
    '{STEP_WRITE, REG_ROW_WIDTH, 24'h000000, '0, 1'b0, '0},
    '{STEP_WRITE, REG_CHANNELS, 24'h000000, '0, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd100, 12'd200, 8'd1, 8'd2, 8'd3}, 1'b1,
      '{29'd15, SAT_HI, SAT_HI, SAT_HI}},
    '{STEP_WRITE, REG_RECIP_SCALE, 24'h0C0000, '0, 1'b0, '0},
    '{STEP_WRITE, REG_CHANNELS, 24'h000002, '0, 1'b0, '0},
    '{STEP_WRITE, REG_ROW_WIDTH, 24'h000003, '0, 1'b0, '0},
    // write to a missing register must not disturb anything
    '{STEP_WRITE, REG_UNMAPPED, 24'hFFFFFF, '0, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd123, 12'd45, 8'd0, 8'd200, 8'd255}, 1'b0, '0},
    '{STEP_WRITE, REG_ZERO_POINT, 24'h0000F6, '0, 1'b0, '0},
    '{STEP_PIXEL, REG_UNMAPPED, 24'd0, '{12'd4095, 12'd0, 8'd140, 8'd90, 8'd60}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_W-1:0] in_pixel_row = '0;
  logic [COORD_W-1:0] in_pixel_col = '0;
  logic [SAMPLE_W-1:0] in_red = '0;
  logic [SAMPLE_W-1:0] in_green = '0;
  logic [SAMPLE_W-1:0] in_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] out_byte_address;
  logic signed [Q_W-1:0] out_q_red;
  logic signed [Q_W-1:0] out_q_green;
  logic signed [Q_W-1:0] out_q_blue;

  quant_cfg_t regs = '{24'd65536, 8'sd0, 8'd0, 8'd0, 4'd0, 13'd1, 5'd3};
  quant_t quant_q[$];
  int n_err = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_normalize_int8_quantize u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_col     (in_pixel_col),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_address (out_byte_address),
    .out_q_red        (out_q_red),
    .out_q_green      (out_q_green),
    .out_q_blue       (out_q_blue)
  );

  function automatic logic signed [Q_W-1:0] quant_sample(input logic [SAMPLE_W-1:0] s,
                                                         input int unsigned mean,
                                                         input int unsigned istd);
    logic [63:0] x;
    logic [63:0] diff;
    logic [63:0] mag;
    logic [63:0] rnd;
    bit neg;
    longint q;
    x = {48'd0, s, 8'd0};
    neg = x < 64'(mean);
    diff = neg ? 64'(mean) - x : x - 64'(mean);
    mag = diff * 64'(istd) * 64'(regs.recip_scale);
    // round half away from zero on the magnitude
    rnd = (mag + (64'd1 << 39)) >> 40;
    q = neg ? -longint'(rnd) : longint'(rnd);
    q = q + longint'(regs.zero_pt);
    if (q < -128) q = -128;
    if (q > 127) q = 127;
    return q[Q_W-1:0];
  endfunction

  function automatic quant_t quantize_pixel(input pixel_t p);
    quant_t r;
    logic [63:0] chans;
    logic [63:0] lin;
    chans = (regs.chans > CHANS_W'(MAX_CH)) ? 64'(MAX_CH) : 64'(regs.chans);
    lin = (64'(p.row) + 64'(regs.row_off)) * 64'(regs.row_w) + 64'(p.col)
          + 64'(regs.col_off);
    r.addr = ADDR_W'(lin * chans + 64'(regs.chan_off));
    r.q_red = quant_sample(p.red, MEAN_RED, ISTD_RED);
    r.q_green = quant_sample(p.green, MEAN_GREEN, ISTD_GREEN);
    r.q_blue = quant_sample(p.blue, MEAN_BLUE, ISTD_BLUE);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Drop valid and hold until every pending result has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (quant_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_RECIP_SCALE: regs.recip_scale = val[RECIP_SCALE_W-1:0];
      REG_ZERO_POINT:  regs.zero_pt = val[Q_W-1:0];
      REG_ROW_OFFSET:  regs.row_off = val[OFFSET_W-1:0];
      REG_COL_OFFSET:  regs.col_off = val[OFFSET_W-1:0];
      REG_CHAN_OFFSET: regs.chan_off = val[CHAN_OFF_W-1:0];
      REG_ROW_WIDTH:   regs.row_w = val[ROW_WIDTH_W-1:0];
      REG_CHANNELS:    regs.chans = val[CHANS_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t p, input bit given, input quant_t want);
    if (!calm)
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_pixel_row <= p.row;
    in_pixel_col <= p.col;
    in_red <= p.red;
    in_green <= p.green;
    in_blue <= p.blue;
    do @(posedge clk); while (in_ready !== 1'b1);
    quant_q.push_back(given ? want : quantize_pixel(p));
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  initial begin : result_side
    int hold_left;
    quant_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (quant_q.size() == 0) begin
          $error("result with no request pending: address %0d", out_byte_address);
          n_err++;
        end else begin
          want = quant_q.pop_front();
          check_field("byte_address", longint'(want.addr), longint'(out_byte_address));
          check_field("q_red", longint'(want.q_red), longint'(out_q_red));
          check_field("q_green", longint'(want.q_green), longint'(out_q_green));
          check_field("q_blue", longint'(want.q_blue), longint'(out_q_blue));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin : pixel_side
    int i;
    int ph;
    int k;
    pixel_t px;
    cfg_data_t scale;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < DIR_N; i++) begin
      if (DIR_TBL[i].kind == STEP_WRITE) begin
        write_reg(DIR_TBL[i].idx, DIR_TBL[i].data);
      end else begin
        send_pixel(DIR_TBL[i].px, DIR_TBL[i].given, DIR_TBL[i].q);
      end
    end
    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 7))
        0: scale = '0;
        1: scale = 24'hFFFFFF;
        2: scale = cfg_data_t'(RECIP_SCALE_RST);
        default: scale = cfg_data_t'($urandom_range(1, 24'h3FFFFF));
      endcase
      write_reg(REG_RECIP_SCALE, scale);
      write_reg(REG_ZERO_POINT, cfg_data_t'($urandom_range(0, 255)));
      write_reg(REG_ROW_OFFSET, cfg_data_t'($urandom_range(0, 255)));
      write_reg(REG_COL_OFFSET, cfg_data_t'($urandom_range(0, 255)));
      write_reg(REG_CHAN_OFFSET, cfg_data_t'($urandom_range(0, 15)));
      write_reg(REG_ROW_WIDTH, cfg_data_t'($urandom_range(0, 8191)));
      write_reg(REG_CHANNELS, cfg_data_t'($urandom_range(0, 31)));
      calm = (ph == 1);
      for (k = 0; k < 110; k++) begin
        // stall the result side while requests keep coming, to fill the pipe
        if (ph == 3 && k == 20) hold_req = 1'b1;
        px.row = COORD_W'($urandom);
        px.col = COORD_W'($urandom);
        px.red = rand_sample();
        px.green = rand_sample();
        px.blue = rand_sample();
        send_pixel(px, 1'b0, '0);
      end
    end
    wait_all_results();
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
